// File: sv/md5_stream_hash_keyed_iv_assert.svh
// Assertion macros for the MD5 port checker
`ifndef MD5_STREAM_HASH_KEYED_IV_ASSERT_SVH
`define MD5_STREAM_HASH_KEYED_IV_ASSERT_SVH

// Check cons in the cycle after ante
`define MD5_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 assertion failed");

// Check cons in the same cycle as ante
`define MD5_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 assertion failed");

`endif

// File: sv/md5_pkg.sv
// Types, constants and step tables for the MD5 stream hash
package md5_pkg;

    localparam logic [31:0] IV_A_RST = 32'h67452301;
    localparam logic [31:0] IV_B_RST = 32'hefcdab89;
    localparam logic [31:0] IV_C_RST = 32'h98badcfe;
    localparam logic [31:0] IV_D_RST = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_STEP = 6'd63;

    // Configuration register indexes
    localparam logic [1:0] REG_IV_A = 2'd0;
    localparam logic [1:0] REG_IV_B = 2'd1;
    localparam logic [1:0] REG_IV_C = 2'd2;
    localparam logic [1:0] REG_IV_D = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
    } md5_out_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } md5_bsel_t;

    typedef struct packed {
        logic       load_iv;
        logic       wr_byte;
        md5_bsel_t  byte_sel;
        logic       add_bits;
        logic       load_work;
        logic       step;
        logic [5:0] step_idx;
        logic       add_chain;
        logic       emit;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
        logic       len_zero;
    } md5_stat_t;

    // Additive constant of each step
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount by round and step within a group of four
    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] r;
        unique case ({i[5:4], i[1:0]})
            4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/md5_stream_hash_keyed_iv.sv
// Top level of the MD5 stream hash with configurable initial value
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_ready  | in_data  (data_byte, has_byte, last)
//  out     | out_valid / out_ready| out_data (digest_a .. digest_d)
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// A byte transaction that fills the 64-byte block also runs the 64 steps and
// the chaining add, set by the single shared step unit.
// A closing transaction pads the block byte by byte and runs one or two more
// compressions before the digest shows; input stalls until then.
// Reset clears control and loads the standard initial value; no clearing pass.
// A pending digest holds in the output register while input continues.
module md5_stream_hash_keyed_iv
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  md5_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output md5_out_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    md5_cmd_t  cmd;
    md5_stat_t stat;

    md5_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_byte  (in_data.has_byte),
        .last      (in_data.last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    md5_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (in_data.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .digest    (out_data)
    );

endmodule

// File: sv/md5_ctrl.sv
// Sequencer for byte intake, padding, compression and digest hand-off
module md5_ctrl
    import md5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      has_byte,
    input  logic      last,
    output logic      out_valid,
    input  logic      out_ready,
    input  md5_stat_t stat,
    output md5_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_COMP,
        S_ADD,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       pos_full;

    assign pos_full  = (stat.byte_pos == LAST_POS);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.byte_sel   = BSEL_DATA;
        cmd.step_idx   = step_reg;
        state_next     = state_reg;
        ret_next       = ret_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (has_byte || last))
                begin
                    cmd.load_iv = stat.len_zero && (stat.byte_pos == 6'd0);
                    if (has_byte)
                    begin
                        cmd.wr_byte  = 1'b1;
                        cmd.add_bits = 1'b1;
                    end
                    if (has_byte && pos_full)
                    begin
                        cmd.load_work = 1'b1;
                        step_next     = 6'd0;
                        state_next    = S_COMP;
                        ret_next      = last ? S_PAD80 : S_IDLE;
                    end
                    else if (last)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = BSEL_PAD;
                state_next   = S_ZERO;
                if (pos_full)
                begin
                    cmd.load_work = 1'b1;
                    step_next     = 6'd0;
                    state_next    = S_COMP;
                    ret_next      = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (stat.byte_pos == LEN_POS)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.wr_byte  = 1'b1;
                    cmd.byte_sel = BSEL_ZERO;
                    if (pos_full)
                    begin
                        cmd.load_work = 1'b1;
                        step_next     = 6'd0;
                        state_next    = S_COMP;
                        ret_next      = S_ZERO;
                    end
                end
            end
            S_LEN:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = BSEL_LEN;
                if (pos_full)
                begin
                    cmd.load_work = 1'b1;
                    step_next     = 6'd0;
                    state_next    = S_COMP;
                    ret_next      = S_DONE;
                end
            end
            S_COMP:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                state_next    = ret_reg;
            end
            S_DONE:
            begin
                // Hold the digest until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            step_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/md5_dp.sv
// MD5 datapath: iv registers, block buffer, step unit, chaining and digest
module md5_dp
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  data_byte,
    input  md5_cmd_t    cmd,
    output md5_stat_t   stat,
    output md5_out_t    digest
);

    logic [31:0] iv_reg [4];
    logic [31:0] chain_reg [4];
    logic [31:0] block_reg [16];
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [63:0] bit_count_reg;
    logic [5:0]  byte_pos_reg;
    md5_out_t    digest_reg;

    logic [7:0]  byte_val;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] sum_val;
    logic [31:0] rot_val;
    logic [4:0]  rot_amt;
    logic [5:0]  i_idx;

    assign stat.byte_pos = byte_pos_reg;
    assign stat.len_zero = (bit_count_reg == 64'd0);
    assign digest        = digest_reg;
    assign i_idx         = cmd.step_idx;

    // Select the byte that goes into the block
    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_DATA: byte_val = data_byte;
            BSEL_PAD:  byte_val = PAD_BYTE;
            BSEL_ZERO: byte_val = 8'h00;
            BSEL_LEN:  byte_val = bit_count_reg[{byte_pos_reg[2:0], 3'b000} +: 8];
            default:   byte_val = 8'h00;
        endcase
    end

    // Round function and message word index
    always_comb
    begin
        unique case (i_idx[5:4])
            2'd0:
            begin
                f_val = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
                g_idx = i_idx[3:0];
            end
            2'd1:
            begin
                f_val = (wb_reg & wd_reg) | (wc_reg & ~wd_reg);
                g_idx = 4'({i_idx[3:0], 2'b00} + i_idx[3:0] + 4'd1);
            end
            2'd2:
            begin
                f_val = wb_reg ^ wc_reg ^ wd_reg;
                g_idx = 4'({i_idx[3:0], 1'b0} + i_idx[3:0] + 4'd5);
            end
            default:
            begin
                f_val = wc_reg ^ (wb_reg | ~wd_reg);
                g_idx = 4'({i_idx[3:0], 3'b000} - i_idx[3:0]);
            end
        endcase
        rot_amt = md5_rot(i_idx);
        sum_val = wa_reg + f_val + block_reg[g_idx] + md5_k(i_idx);
        rot_val = (sum_val << rot_amt) | (sum_val >> (6'd32 - {1'b0, rot_amt}));
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg[REG_IV_A] <= IV_A_RST;
            iv_reg[REG_IV_B] <= IV_B_RST;
            iv_reg[REG_IV_C] <= IV_C_RST;
            iv_reg[REG_IV_D] <= IV_D_RST;
        end
        else if (cfg_we)
        begin
            iv_reg[cfg_index] <= cfg_data;
        end
    end

    // Length and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= 64'd0;
            byte_pos_reg  <= 6'd0;
        end
        else if (cmd.emit)
        begin
            bit_count_reg <= 64'd0;
            byte_pos_reg  <= 6'd0;
        end
        else
        begin
            if (cmd.add_bits)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
            end
            if (cmd.wr_byte)
            begin
                byte_pos_reg <= byte_pos_reg + 6'd1;
            end
        end
    end

    // Block buffer, byte lanes little-endian
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            block_reg[byte_pos_reg[5:2]][{byte_pos_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
    end

    // Chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV_A_RST;
            chain_reg[1] <= IV_B_RST;
            chain_reg[2] <= IV_C_RST;
            chain_reg[3] <= IV_D_RST;
        end
        else if (cmd.load_iv)
        begin
            chain_reg <= iv_reg;
        end
        else if (cmd.add_chain)
        begin
            chain_reg[0] <= chain_reg[0] + wa_reg;
            chain_reg[1] <= chain_reg[1] + wb_reg;
            chain_reg[2] <= chain_reg[2] + wc_reg;
            chain_reg[3] <= chain_reg[3] + wd_reg;
        end
    end

    // Working words: load at block start, advance one step a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            wa_reg <= chain_reg[0];
            wb_reg <= chain_reg[1];
            wc_reg <= chain_reg[2];
            wd_reg <= chain_reg[3];
        end
        else if (cmd.step)
        begin
            wa_reg <= wd_reg;
            wd_reg <= wc_reg;
            wc_reg <= wb_reg;
            wb_reg <= wb_reg + rot_val;
        end
    end

    // Digest output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            digest_reg.digest_a <= chain_reg[0];
            digest_reg.digest_b <= chain_reg[1];
            digest_reg.digest_c <= chain_reg[2];
            digest_reg.digest_d <= chain_reg[3];
        end
    end

endmodule

// File: sv/md5_chk.sv
// Port-level checker for the MD5 stream hash, bound to the top level
`include "md5_stream_hash_keyed_iv_assert.svh"

module md5_chk
    import md5_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input md5_in_t     in_data,
    input logic        out_valid,
    input logic        out_ready,
    input md5_out_t    out_data
);

    // Hold a stalled digest
    `MD5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // A closing transaction starts padding, so input stalls
    `MD5_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && in_data.last, !in_ready)
    // An empty non-closing transaction leaves the block ready
    `MD5_ASSERT_NEXT(a_empty_ready,
        in_valid && in_ready && !in_data.last && !in_data.has_byte, in_ready)
    // A new digest appears together with the return to intake
    `MD5_ASSERT_SAME(a_digest_idle, $rose(out_valid), in_ready)

endmodule

bind md5_stream_hash_keyed_iv md5_chk u_chk (.*);

// File: bench/md5_stream_hash_keyed_iv_tb.sv
// Self-checking bench for the MD5 stream hash with configurable initial value
module md5_stream_hash_keyed_iv_tb;
    import md5_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    md5_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    md5_out_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    md5_stream_hash_keyed_iv uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the hash state
    logic [31:0] iv_words [4];
    logic [31:0] chain [4];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    logic [5:0]  lane;

    md5_in_t     byte_queue [$];
    md5_out_t    digest_queue [$];
    int          mismatches;
    int          accepted;
    int          queued_total;
    bit          stall_long;
    bit          feeding_done;
    bit          in_fire;
    bit          out_fire;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Advance the shadow chaining words by one full block
    function automatic void run_block();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = a + f + blk[g] + md5_k(i[5:0]);
            t = 32'({t, t} >> (32 - md5_rot(i[5:0])));
            t = b + t;
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    function automatic void push_byte(logic [7:0] v);
        blk[lane[5:2]][lane[1:0] * 8 +: 8] = v;
        lane = lane + 6'd1;
        if (lane == 6'd0)
            run_block();
    endfunction

    // Predict the digest caused by one accepted transaction
    function automatic void hash_item(md5_in_t it);
        logic [63:0] len;
        if (!it.has_byte && !it.last)
            return;
        if (msg_bits == 64'd0 && lane == 6'd0)
            for (int k = 0; k < 4; k++)
                chain[k] = iv_words[k];
        if (it.has_byte)
        begin
            push_byte(it.data_byte);
            msg_bits += 64'd8;
        end
        if (!it.last)
            return;
        len = msg_bits;
        push_byte(PAD_BYTE);
        while (lane != LEN_POS)
            push_byte(8'h00);
        for (int k = 0; k < 8; k++)
            push_byte(len[8 * k +: 8]);
        digest_queue.push_back({chain[0], chain[1], chain[2], chain[3]});
        msg_bits = 64'd0;
        lane = 6'd0;
        for (int k = 0; k < 4; k++)
            chain[k] = iv_words[k];
    endfunction

    // Driver: offer queued transactions with random gaps
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            else if (!in_valid && byte_queue.size() > 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                else
                begin
                    in_data <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Accepted inputs feed the predictor
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            hash_item(in_data);
            accepted++;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    int recv_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_long)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (out_fire)
            begin
                recv_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0;
                out_ready <= (recv_gap == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: compare each digest with the oldest prediction
    always @(posedge clk)
    begin
        md5_out_t want;
        out_fire = rst_n && out_valid && out_ready;
        if (out_fire)
        begin
            if (digest_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest %h", out_data);
            end
            else
            begin
                want = digest_queue.pop_front();
                if (want !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: expected %h got %h", want, out_data);
                end
            end
        end
    end

    task automatic queue_item(logic [7:0] v, logic h, logic l);
        md5_in_t it;
        it.data_byte = v;
        it.has_byte = h;
        it.last = l;
        byte_queue.push_back(it);
        queued_total++;
    endtask

    task automatic queue_message(int n, bit close_with_byte);
        for (int i = 0; i < n; i++)
            queue_item(8'($urandom_range(0, 255)), 1'b1,
                close_with_byte && i == n - 1);
        if (!close_with_byte || n == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Wait until every transaction is accepted and every digest drained
    task automatic drain();
        while (accepted < queued_total || digest_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_iv(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        iv_words[idx] = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_IV_A;
        cfg_data = '0;
        stall_long = 1'b0;
        mismatches = 0;
        accepted = 0;
        queued_total = 0;
        send_gap = 0;
        recv_gap = 0;
        iv_words = '{IV_A_RST, IV_B_RST, IV_C_RST, IV_D_RST};
        chain = iv_words;
        blk = '{default: '0};
        msg_bits = '0;
        lane = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, empty items, byte extremes, pad boundaries
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'h12, 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h80, 1'b1, 1'b0);
        queue_item(8'h7f, 1'b1, 1'b0);
        queue_item(8'h55, 1'b0, 1'b1);
        queue_message(55, 1'b1);
        queue_message(56, 1'b0);
        queue_message(64, 1'b1);
        drain();

        // Configuration values (all zero, all ones, random, standard), each followed by a few messages
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int r = 0; r < 4; r++)
                write_iv(r[1:0], phase == 0 ? 32'h0 : phase == 1 ? 32'hffffffff :
                    phase == 2 ? $urandom() : (r == 0 ? IV_A_RST : r == 1 ? IV_B_RST :
                    r == 2 ? IV_C_RST : IV_D_RST));
            queue_item(8'h00, 1'b0, 1'b1);
            for (int m = 0; m < 4; m++)
                queue_message($urandom_range(0, 20), 1'($urandom_range(0, 1)));
            drain();
        end

        // Long receiver hold-off while the sender keeps offering
        stall_long = 1'b1;
        for (int m = 0; m < 4; m++)
            queue_message($urandom_range(1, 6), 1'b1);
        repeat (2000) @(posedge clk);
        stall_long = 1'b0;
        drain();

        // Random messages, mostly short, with occasional block-sized ones
        while (queued_total < 1050)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else if (kind == 1)
                queue_message($urandom_range(55, 130), 1'($urandom_range(0, 1)));
            else
            begin
                for (int i = $urandom_range(0, 12); i > 0; i--)
                begin
                    if ($urandom_range(0, 7) == 0)
                        queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                end
                queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
            if ($urandom_range(0, 30) == 0)
                drain();
        end
        drain();

        if (mismatches == 0 && digest_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
